// ===== src/csf_pkg.sv =====
package csf_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRAILING  = 3'd1;
  localparam logic [2:0] ERR_MISPLACED = 3'd2;
  localparam logic [2:0] ERR_AFTER_QT  = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;
  localparam logic [2:0] ERR_COLCOUNT  = 3'd5;

  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_INT    = 2'd1;
  localparam logic [1:0] KIND_FLOAT  = 2'd2;

  typedef enum logic [2:0] {
    CC_OTHER,
    CC_DIGIT,
    CC_DOT,
    CC_COMMA,
    CC_QUOTE,
    CC_EOL
  } char_class_t;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QUOTE_SEEN
  } parse_mode_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic [9:0] field_index;
    logic [1:0] field_kind;
    logic       row_end;
    logic [2:0] error_code;
  } out_word_t;

  typedef struct packed {
    char_class_t cls;
    logic [7:0]  char_byte;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_write_t;

endpackage

// ===== src/csv_field_splitter_core.sv =====
// channel  dir  handshake             payload
// in_      in   in_valid / in_stall   csf_pkg::in_word_t  (req_type, char_byte)
// out_     out  out_valid / out_stall csf_pkg::out_word_t (byte, field end, row end, error)
// cfg_     in   cfg_we                cfg_wdata expected_columns, 11 bits
// one word per cycle sustained unless out_stall holds a result; parser state updates once per popped word
// with an empty queue an accepted word goes through a queue entry, then the result register
// a 4-entry queue sits between classifier and parser, in_stall rises only when full
// out_stall with a valid result holds the result register and stops the parser; input keeps filling the queue
// synchronous active-low reset clears parser state, queue and expected_columns
module csv_field_splitter_core #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  csf_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output csf_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata
);

  csf_pkg::q_write_t q_wr;
  csf_pkg::q_entry_t q_head;
  logic              q_full;
  logic              q_valid;
  logic              pop;

  csf_front u_front (
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_wr     (q_wr)
  );

  csf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .pop     (pop),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  csf_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== src/csf_front.sv =====
module csf_front (
  input  logic              in_valid,
  input  csf_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              in_stall,
  output csf_pkg::q_write_t q_wr
);

  csf_pkg::char_class_t cls;

  always_comb begin
    if (in_word.req_type) begin
      cls = csf_pkg::CC_EOL;
    end else if (in_word.char_byte inside {[csf_pkg::CH_ZERO:csf_pkg::CH_NINE]}) begin
      cls = csf_pkg::CC_DIGIT;
    end else begin
      case (in_word.char_byte)
        csf_pkg::CH_DOT:   cls = csf_pkg::CC_DOT;
        csf_pkg::CH_COMMA: cls = csf_pkg::CC_COMMA;
        csf_pkg::CH_QUOTE: cls = csf_pkg::CC_QUOTE;
        default:           cls = csf_pkg::CC_OTHER;
      endcase
    end
  end

  assign in_stall             = q_full;
  assign q_wr.push            = in_valid && !q_full;
  assign q_wr.entry.cls       = cls;
  assign q_wr.entry.char_byte = in_word.char_byte;

endmodule

// ===== src/csf_queue.sv =====
module csf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  csf_pkg::q_write_t q_wr,
  input  logic              pop,
  output logic              q_full,
  output logic              q_valid,
  output csf_pkg::q_entry_t q_head
);

  localparam int CW = csf_pkg::QUEUE_AW + 1;

  csf_pkg::q_entry_t                mem_r [csf_pkg::QUEUE_DEPTH];
  logic [csf_pkg::QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [csf_pkg::QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             do_pop;

  assign q_full  = (count_r == CW'(csf_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = q_wr.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(q_wr.push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(csf_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_wr.push)
    else $error("queue written while full");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != CW'(csf_pkg::QUEUE_DEPTH)) |->
      ((wr_ptr_r - rd_ptr_r) == count_r[csf_pkg::QUEUE_AW-1:0]))
    else $error("queue pointers disagree with count");

endmodule

// ===== src/csf_back.sv =====
module csf_back #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               q_valid,
  input  csf_pkg::q_entry_t  q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output csf_pkg::out_word_t out_word
);

  localparam int IDX_CAP = (MAX_COLUMNS - 1 < 1023) ? MAX_COLUMNS - 1 : 1023;

  csf_pkg::parse_mode_t mode_r, mode_nxt;
  logic                 prev_comma_r, prev_comma_nxt;
  logic [10:0]          fields_r, fields_nxt;
  logic                 dot_r, dot_nxt;
  logic                 nonnum_r, nonnum_nxt;
  logic                 has_r, has_nxt;
  logic                 skip_r, skip_nxt;
  logic [10:0]          expected_r;

  logic                 out_valid_r;
  csf_pkg::out_word_t   out_word_r;
  csf_pkg::out_word_t   res;
  logic                 res_valid;

  logic                 advance;
  logic                 is_eol, is_comma, is_quote, is_dot, is_num;
  logic [10:0]          fields_inc;
  logic [9:0]           cur_index;
  logic [1:0]           cur_kind;
  logic                 bad_now, bad_after;

  assign advance   = !out_valid_r || !out_stall;
  assign pop       = q_valid && advance;

  assign is_eol    = (q_head.cls == csf_pkg::CC_EOL);
  assign is_comma  = (q_head.cls == csf_pkg::CC_COMMA);
  assign is_quote  = (q_head.cls == csf_pkg::CC_QUOTE);
  assign is_dot    = (q_head.cls == csf_pkg::CC_DOT);
  assign is_num    = (q_head.cls == csf_pkg::CC_DIGIT) || is_dot;

  assign fields_inc = (fields_r != 11'h7FF) ? fields_r + 11'd1 : fields_r;
  assign cur_index  = (fields_r > 11'(IDX_CAP)) ? 10'(IDX_CAP) : fields_r[9:0];
  assign cur_kind   = (!has_r || nonnum_r) ? csf_pkg::KIND_STRING :
                      (dot_r ? csf_pkg::KIND_FLOAT : csf_pkg::KIND_INT);
  assign bad_now    = (expected_r != '0) && (fields_r != expected_r);
  assign bad_after  = (expected_r != '0) && (fields_inc != expected_r);

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    prev_comma_nxt = prev_comma_r;
    fields_nxt     = fields_r;
    dot_nxt        = dot_r;
    nonnum_nxt     = nonnum_r;
    has_nxt        = has_r;
    skip_nxt       = skip_r;
    if (pop) begin
      if (skip_r || is_eol) begin
        if (is_eol) begin
          skip_nxt       = 1'b0;
          mode_nxt       = csf_pkg::MODE_START;
          prev_comma_nxt = 1'b0;
          fields_nxt     = '0;
          dot_nxt        = 1'b0;
          nonnum_nxt     = 1'b0;
          has_nxt        = 1'b0;
        end
      end else begin
        case (mode_r)
          csf_pkg::MODE_PLAIN: begin
            if (is_comma) begin
              fields_nxt     = fields_inc;
              dot_nxt        = 1'b0;
              nonnum_nxt     = 1'b0;
              has_nxt        = 1'b0;
              prev_comma_nxt = 1'b1;
              mode_nxt       = csf_pkg::MODE_START;
            end else if (is_quote) begin
              skip_nxt = 1'b1;
            end else begin
              has_nxt    = 1'b1;
              dot_nxt    = dot_r || is_dot;
              nonnum_nxt = nonnum_r || !is_num;
            end
          end
          csf_pkg::MODE_QUOTED: begin
            if (is_quote) begin
              mode_nxt = csf_pkg::MODE_QUOTE_SEEN;
            end else begin
              has_nxt    = 1'b1;
              dot_nxt    = dot_r || is_dot;
              nonnum_nxt = nonnum_r || !is_num;
            end
          end
          csf_pkg::MODE_QUOTE_SEEN: begin
            if (is_quote) begin
              has_nxt    = 1'b1;
              nonnum_nxt = 1'b1;
              mode_nxt   = csf_pkg::MODE_QUOTED;
            end else if (is_comma) begin
              fields_nxt     = fields_inc;
              dot_nxt        = 1'b0;
              nonnum_nxt     = 1'b0;
              has_nxt        = 1'b0;
              prev_comma_nxt = 1'b1;
              mode_nxt       = csf_pkg::MODE_START;
            end else begin
              skip_nxt = 1'b1;
            end
          end
          default: begin
            if (is_comma) begin
              fields_nxt     = fields_inc;
              dot_nxt        = 1'b0;
              nonnum_nxt     = 1'b0;
              has_nxt        = 1'b0;
              prev_comma_nxt = 1'b1;
            end else if (is_quote) begin
              prev_comma_nxt = 1'b0;
              dot_nxt        = 1'b0;
              nonnum_nxt     = 1'b0;
              has_nxt        = 1'b0;
              mode_nxt       = csf_pkg::MODE_QUOTED;
            end else begin
              prev_comma_nxt = 1'b0;
              dot_nxt        = is_dot;
              nonnum_nxt     = !is_num;
              has_nxt        = 1'b1;
              mode_nxt       = csf_pkg::MODE_PLAIN;
            end
          end
        endcase
      end
    end
  end

  // result word
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (!skip_r) begin
      if (is_eol) begin
        res_valid = 1'b1;
        case (mode_r)
          csf_pkg::MODE_QUOTED: begin
            res.error_code = csf_pkg::ERR_UNTERM;
          end
          csf_pkg::MODE_PLAIN, csf_pkg::MODE_QUOTE_SEEN: begin
            res.field_end   = 1'b1;
            res.field_index = cur_index;
            res.field_kind  = cur_kind;
            if (bad_after) begin
              res.error_code = csf_pkg::ERR_COLCOUNT;
            end else begin
              res.row_end = 1'b1;
            end
          end
          default: begin
            if (prev_comma_r) begin
              res.error_code = csf_pkg::ERR_TRAILING;
            end else if (bad_now) begin
              res.error_code = csf_pkg::ERR_COLCOUNT;
            end else begin
              res.row_end = 1'b1;
            end
          end
        endcase
      end else begin
        case (mode_r)
          csf_pkg::MODE_PLAIN: begin
            res_valid = 1'b1;
            if (is_comma) begin
              res.field_end   = 1'b1;
              res.field_index = cur_index;
              res.field_kind  = cur_kind;
            end else if (is_quote) begin
              res.error_code = csf_pkg::ERR_MISPLACED;
            end else begin
              res.out_byte   = q_head.char_byte;
              res.byte_valid = 1'b1;
            end
          end
          csf_pkg::MODE_QUOTED: begin
            if (!is_quote) begin
              res_valid      = 1'b1;
              res.out_byte   = q_head.char_byte;
              res.byte_valid = 1'b1;
            end
          end
          csf_pkg::MODE_QUOTE_SEEN: begin
            res_valid = 1'b1;
            if (is_quote) begin
              res.out_byte   = q_head.char_byte;
              res.byte_valid = 1'b1;
            end else if (is_comma) begin
              res.field_end   = 1'b1;
              res.field_index = cur_index;
              res.field_kind  = cur_kind;
            end else begin
              res.error_code = csf_pkg::ERR_AFTER_QT;
            end
          end
          default: begin
            if (is_comma) begin
              res_valid       = 1'b1;
              res.field_end   = 1'b1;
              res.field_index = cur_index;
              res.field_kind  = cur_kind;
            end else if (!is_quote) begin
              res_valid      = 1'b1;
              res.out_byte   = q_head.char_byte;
              res.byte_valid = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= csf_pkg::MODE_START;
      prev_comma_r <= 1'b0;
      fields_r     <= '0;
      dot_r        <= 1'b0;
      nonnum_r     <= 1'b0;
      has_r        <= 1'b0;
      skip_r       <= 1'b0;
      expected_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      prev_comma_r <= prev_comma_nxt;
      fields_r     <= fields_nxt;
      dot_r        <= dot_nxt;
      nonnum_r     <= nonnum_nxt;
      has_r        <= has_nxt;
      skip_r       <= skip_nxt;
      if (cfg_we) begin
        expected_r <= cfg_wdata;
      end
      if (advance) begin
        out_valid_r <= pop && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_comma_in_start: assert property (@(posedge clk) disable iff (!rst_n)
    prev_comma_r |-> (mode_r == csf_pkg::MODE_START))
    else $error("comma flag set outside field start");

  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.field_end) |->
      (out_word_r.error_code == csf_pkg::ERR_NONE ||
       out_word_r.error_code == csf_pkg::ERR_COLCOUNT))
    else $error("field end with parse error");

  a_row_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.row_end) |->
      (out_word_r.error_code == csf_pkg::ERR_NONE && !out_word_r.byte_valid))
    else $error("row end with error or byte");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skip_r) |=> (out_valid_r == $past(out_valid_r && out_stall)))
    else $error("result produced while skipping");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int MAX_COLS = 1024;
  localparam int IDX_CAP = (MAX_COLS - 1 < 1023) ? MAX_COLS - 1 : 1023;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  typedef enum {CHK_PRED, CHK_SILENT, CHK_GIVEN} chk_t;
  typedef enum {FL_CLEAN, FL_TRAIL, FL_UNTERM, FL_MISQ, FL_AFTERQ, FL_NOISE} flaw_t;

  typedef struct {
    bit                 is_cfg;
    logic [10:0]        cols;
    csf_pkg::in_word_t  w;
    chk_t               k;
    csf_pkg::out_word_t r;
  } drow_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  csf_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  csf_pkg::out_word_t out_word;
  logic               cfg_we;
  logic [10:0]        cfg_wdata;

  // line parser state as seen from the outside
  csf_pkg::parse_mode_t ps_mode;
  bit          after_comma;
  bit          has_dot;
  bit          has_alpha;
  bit          has_content;
  bit          skipping;
  int unsigned col_count;
  logic [10:0] want_cols;

  csf_pkg::out_word_t due_words[$];
  drow_t              dir_rows[$];

  bit idle_on;
  bit stall_on;
  bit long_hold_req;
  int fails;
  int words_taken;
  int checked;
  int field_ends;
  int row_ends;
  int errs_seen;
  int quiet_cycles;

  csv_field_splitter_core #(
    .MAX_COLUMNS(MAX_COLS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_field();
    has_dot = 1'b0;
    has_alpha = 1'b0;
    has_content = 1'b0;
  endfunction

  function automatic void new_line();
    ps_mode = csf_pkg::MODE_START;
    after_comma = 1'b0;
    col_count = 0;
    clear_field();
  endfunction

  function automatic void close_field(inout csf_pkg::out_word_t r);
    r.field_end = 1'b1;
    r.field_index = (col_count > IDX_CAP) ? 10'(IDX_CAP) : 10'(col_count);
    if (!has_content || has_alpha) r.field_kind = csf_pkg::KIND_STRING;
    else if (has_dot) r.field_kind = csf_pkg::KIND_FLOAT;
    else r.field_kind = csf_pkg::KIND_INT;
    if (col_count < 2047) col_count++;
    clear_field();
  endfunction

  function automatic void take_char(logic [7:0] c, inout csf_pkg::out_word_t r);
    has_content = 1'b1;
    if (c == csf_pkg::CH_DOT) has_dot = 1'b1;
    else if (c < csf_pkg::CH_ZERO || c > csf_pkg::CH_NINE) has_alpha = 1'b1;
    r.out_byte = c;
    r.byte_valid = 1'b1;
  endfunction

  // returns 1 when the word yields a result
  function automatic bit split_char(input csf_pkg::in_word_t w,
                                    output csf_pkg::out_word_t r);
    logic [7:0] c;
    c = w.char_byte;
    r = '0;
    if (skipping) begin
      if (w.req_type) begin
        skipping = 1'b0;
        new_line();
      end
      return 1'b0;
    end
    if (w.req_type) begin
      if (ps_mode == csf_pkg::MODE_QUOTED) begin
        r.error_code = csf_pkg::ERR_UNTERM;
      end else if (ps_mode == csf_pkg::MODE_START && after_comma) begin
        r.error_code = csf_pkg::ERR_TRAILING;
      end else begin
        if (ps_mode != csf_pkg::MODE_START) close_field(r);
        if (want_cols != 0 && col_count != want_cols) r.error_code = csf_pkg::ERR_COLCOUNT;
        else r.row_end = 1'b1;
      end
      new_line();
      return 1'b1;
    end
    case (ps_mode)
      csf_pkg::MODE_PLAIN: begin
        if (c == csf_pkg::CH_COMMA) begin
          close_field(r);
          after_comma = 1'b1;
          ps_mode = csf_pkg::MODE_START;
        end else if (c == csf_pkg::CH_QUOTE) begin
          r.error_code = csf_pkg::ERR_MISPLACED;
          skipping = 1'b1;
        end else begin
          take_char(c, r);
        end
        return 1'b1;
      end
      csf_pkg::MODE_QUOTED: begin
        if (c == csf_pkg::CH_QUOTE) begin
          ps_mode = csf_pkg::MODE_QUOTE_SEEN;
          return 1'b0;
        end
        take_char(c, r);
        return 1'b1;
      end
      csf_pkg::MODE_QUOTE_SEEN: begin
        if (c == csf_pkg::CH_QUOTE) begin
          take_char(c, r);
          ps_mode = csf_pkg::MODE_QUOTED;
        end else if (c == csf_pkg::CH_COMMA) begin
          close_field(r);
          after_comma = 1'b1;
          ps_mode = csf_pkg::MODE_START;
        end else begin
          r.error_code = csf_pkg::ERR_AFTER_QT;
          skipping = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        if (c == csf_pkg::CH_COMMA) begin
          close_field(r);
          after_comma = 1'b1;
          ps_mode = csf_pkg::MODE_START;
          return 1'b1;
        end
        after_comma = 1'b0;
        clear_field();
        if (c == csf_pkg::CH_QUOTE) begin
          ps_mode = csf_pkg::MODE_QUOTED;
          return 1'b0;
        end
        take_char(c, r);
        ps_mode = csf_pkg::MODE_PLAIN;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic csf_pkg::out_word_t mk(logic [7:0] b, logic bv, logic fe,
                                            logic [9:0] idx, logic [1:0] kind,
                                            logic re, logic [2:0] err);
    csf_pkg::out_word_t r;
    r.out_byte = b;
    r.byte_valid = bv;
    r.field_end = fe;
    r.field_index = idx;
    r.field_kind = kind;
    r.row_end = re;
    r.error_code = err;
    return r;
  endfunction

  function automatic csf_pkg::in_word_t chw(logic [7:0] c);
    return csf_pkg::in_word_t'({1'b0, c});
  endfunction

  function automatic csf_pkg::in_word_t eolw();
    return csf_pkg::in_word_t'({1'b1, 8'($urandom)});
  endfunction

  function automatic logic [7:0] digit();
    return 8'(csf_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == csf_pkg::CH_COMMA || c == csf_pkg::CH_QUOTE) c = "a";
    return c;
  endfunction

  task automatic put(bit eol, logic [7:0] c, chk_t k, csf_pkg::out_word_t r);
    drow_t d;
    d.is_cfg = 1'b0;
    d.cols = '0;
    d.w = csf_pkg::in_word_t'({eol, c});
    d.k = k;
    d.r = r;
    dir_rows = {dir_rows, d};
  endtask

  task automatic put_cols(logic [10:0] v);
    drow_t d;
    d.is_cfg = 1'b1;
    d.cols = v;
    d.w = '0;
    d.k = CHK_SILENT;
    d.r = '0;
    dir_rows = {dir_rows, d};
  endtask

  task automatic feed(csf_pkg::in_word_t w, chk_t k, csf_pkg::out_word_t given);
    csf_pkg::out_word_t p;
    bit got;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!skipping) words_taken++;
    got = split_char(w, p);
    case (k)
      CHK_PRED: if (got) due_words = {due_words, p};
      CHK_GIVEN: due_words = {due_words, given};
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_cols(logic [10:0] v);
    wait_drained();
    // words that give no result may still sit in the queue
    repeat (64) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_cols = v;
  endtask

  task automatic add_junk(ref csf_pkg::in_word_t q[$]);
    repeat ($urandom_range(0, 4)) q = {q, chw(8'($urandom))};
  endtask

  task automatic add_field(ref csf_pkg::in_word_t q[$]);
    case ($urandom_range(0, 5))
      0: ;
      1: repeat ($urandom_range(1, 5)) q = {q, chw(digit())};
      2: begin
        repeat ($urandom_range(0, 3)) q = {q, chw(digit())};
        q = {q, chw(csf_pkg::CH_DOT)};
        repeat ($urandom_range(0, 3)) q = {q, chw(digit())};
      end
      3: repeat ($urandom_range(1, 6)) q = {q, chw(text_byte())};
      4: begin
        q = {q, chw(csf_pkg::CH_QUOTE)};
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 4))
            0: q = {q, chw(digit())};
            1: q = {q, chw(csf_pkg::CH_DOT)};
            2: q = {q, chw(csf_pkg::CH_COMMA)};
            3: q = {q, chw(csf_pkg::CH_QUOTE), chw(csf_pkg::CH_QUOTE)};
            default: q = {q, chw(text_byte())};
          endcase
        end
        q = {q, chw(csf_pkg::CH_QUOTE)};
      end
      default: begin
        q = {q, chw(csf_pkg::CH_QUOTE)};
        repeat ($urandom_range(1, 3)) q = {q, chw(digit())};
        if ($urandom_range(0, 1)) q = {q, chw(csf_pkg::CH_DOT)};
        repeat ($urandom_range(0, 3)) q = {q, chw(digit())};
        q = {q, chw(csf_pkg::CH_QUOTE)};
      end
    endcase
  endtask

  task automatic random_line();
    csf_pkg::in_word_t ln[$];
    int nf;
    flaw_t flaw;
    logic [7:0] c;
    if (want_cols != 0 && want_cols <= 8 && $urandom_range(0, 1)) nf = want_cols;
    else nf = $urandom_range(0, 6);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) ln = {ln, chw(csf_pkg::CH_COMMA)};
      add_field(ln);
    end
    if ($urandom_range(0, 3) != 0) flaw = FL_CLEAN;
    else flaw = flaw_t'($urandom_range(1, 5));
    if (nf > 0 && flaw inside {FL_UNTERM, FL_MISQ, FL_AFTERQ}) begin
      ln = {ln, chw(csf_pkg::CH_COMMA)};
    end
    case (flaw)
      FL_TRAIL: ln = {ln, chw(csf_pkg::CH_COMMA)};
      FL_UNTERM: begin
        ln = {ln, chw(csf_pkg::CH_QUOTE)};
        repeat ($urandom_range(0, 3)) ln = {ln, chw(text_byte())};
      end
      FL_MISQ: begin
        ln = {ln, chw("a"), chw(csf_pkg::CH_QUOTE)};
        add_junk(ln);
      end
      FL_AFTERQ: begin
        ln = {ln, chw(csf_pkg::CH_QUOTE), chw("b"), chw(csf_pkg::CH_QUOTE)};
        c = text_byte();
        ln = {ln, chw(c)};
        add_junk(ln);
      end
      FL_NOISE: begin
        repeat ($urandom_range(1, 8)) ln = {ln, csf_pkg::in_word_t'(9'($urandom))};
      end
      default: ;
    endcase
    ln = {ln, eolw()};
    foreach (ln[i]) feed(ln[i], CHK_PRED, '0);
  endtask

  task automatic cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    csf_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %p", $time, out_word);
        fails++;
      end else begin
        want = due_words.pop_front();
        cmp("out_byte", want.out_byte, out_word.out_byte);
        cmp("byte_valid", want.byte_valid, out_word.byte_valid);
        cmp("field_end", want.field_end, out_word.field_end);
        cmp("field_index", want.field_index, out_word.field_index);
        cmp("field_kind", want.field_kind, out_word.field_kind);
        cmp("row_end", want.row_end, out_word.row_end);
        cmp("error_code", want.error_code, out_word.error_code);
        checked++;
        if (want.field_end) field_ends++;
        if (want.row_end) row_ends++;
        if (want.error_code != csf_pkg::ERR_NONE) errs_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words outstanding",
               $time, QUIET_LIMIT, due_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int plan [5];
    int mark;
    int lines;
    plan = '{3, 0, 1, 2, 5};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    long_hold_req = 1'b0;
    skipping = 1'b0;
    want_cols = '0;
    new_line();

    // empty line, plain float, quoted with escaped quote, empty field, byte extremes
    put(1'b1, 8'h00, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b0, 10'd0, csf_pkg::KIND_STRING, 1'b1, csf_pkg::ERR_NONE));
    put(1'b0, "1", CHK_PRED, '0);
    put(1'b0, csf_pkg::CH_DOT, CHK_PRED, '0);
    put(1'b0, csf_pkg::CH_COMMA, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b1, 10'd0, csf_pkg::KIND_FLOAT, 1'b0, csf_pkg::ERR_NONE));
    put(1'b0, csf_pkg::CH_QUOTE, CHK_SILENT, '0);
    put(1'b0, "a", CHK_PRED, '0);
    put(1'b0, csf_pkg::CH_QUOTE, CHK_SILENT, '0);
    put(1'b0, csf_pkg::CH_QUOTE, CHK_PRED, '0);
    put(1'b0, csf_pkg::CH_QUOTE, CHK_SILENT, '0);
    put(1'b0, csf_pkg::CH_COMMA, CHK_PRED, '0);
    put(1'b0, csf_pkg::CH_COMMA, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b1, 10'd2, csf_pkg::KIND_STRING, 1'b0, csf_pkg::ERR_NONE));
    put(1'b0, 8'hFF, CHK_PRED, '0);
    put(1'b1, 8'hFF, CHK_PRED, '0);
    // trailing comma
    put(1'b0, csf_pkg::CH_COMMA, CHK_PRED, '0);
    put(1'b1, 8'h00, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b0, 10'd0, csf_pkg::KIND_STRING, 1'b0, csf_pkg::ERR_TRAILING));
    // quote inside plain field, then skip
    put(1'b0, "x", CHK_PRED, '0);
    put(1'b0, csf_pkg::CH_QUOTE, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b0, 10'd0, csf_pkg::KIND_STRING, 1'b0, csf_pkg::ERR_MISPLACED));
    put(1'b0, 8'h00, CHK_SILENT, '0);
    put(1'b1, 8'h00, CHK_SILENT, '0);
    // text after closing quote
    put(1'b0, csf_pkg::CH_QUOTE, CHK_SILENT, '0);
    put(1'b0, csf_pkg::CH_QUOTE, CHK_SILENT, '0);
    put(1'b0, "z", CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b0, 10'd0, csf_pkg::KIND_STRING, 1'b0, csf_pkg::ERR_AFTER_QT));
    put(1'b1, 8'h00, CHK_SILENT, '0);
    // open quote at line end
    put(1'b0, csf_pkg::CH_QUOTE, CHK_SILENT, '0);
    put(1'b1, 8'h00, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b0, 10'd0, csf_pkg::KIND_STRING, 1'b0, csf_pkg::ERR_UNTERM));
    // column count check
    put_cols(11'd2);
    put(1'b0, "0", CHK_PRED, '0);
    put(1'b1, 8'h00, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b1, 10'd0, csf_pkg::KIND_INT, 1'b0, csf_pkg::ERR_COLCOUNT));
    put(1'b1, 8'h00, CHK_GIVEN,
        mk(8'h00, 1'b0, 1'b0, 10'd0, csf_pkg::KIND_STRING, 1'b0, csf_pkg::ERR_COLCOUNT));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cols(dir_rows[i].cols);
      else feed(dir_rows[i].w, dir_rows[i].k, dir_rows[i].r);
    end

    for (int p = 0; p < 5; p++) begin
      write_cols(11'(plan[p]));
      mark = words_taken;
      lines = 0;
      while (words_taken - mark < 90) begin
        random_line();
        lines++;
        if (p == 1 && lines == 2) long_hold_req = 1'b1;
        if (lines % 4 == 0) wait_drained();
      end
    end

    // widest row: index saturates and count misses the limit by one
    write_cols(11'd1024);
    repeat (1024) feed(chw(csf_pkg::CH_COMMA), CHK_PRED, '0);
    feed(chw("x"), CHK_PRED, '0);
    feed(eolw(), CHK_PRED, '0);

    write_cols(11'd4);
    idle_on = 1'b0;
    stall_on = 1'b0;
    mark = words_taken;
    while (words_taken - mark < 200) random_line();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d parsed words, %0d results checked: %0d field ends, %0d row ends,",
             words_taken, checked, field_ends, row_ends);
    $display("%0d line errors, column limits 0 to 1024 and a 1025-field row", errs_seen);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
